// ----- sv/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator package
// Shared constants, register codes, structures and the sine table function.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Default build-time sizes.
  localparam int TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int QVAL_W     = 15;
  localparam int COUNT_W    = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Quarter turn in Q2.30 and the Q1.15 full-scale value.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] Q15_MAX     = 64'd32767;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWEEP_MODE   = 3'd0,
    REG_START_STEP   = 3'd1,
    REG_STEP_DELTA   = 3'd2,
    REG_STEP_RATIO   = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } ssc_reg_e;

  // Sweep modes.
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_LOG    = 1'b1;

  // Reset values of the registers.
  localparam logic [31:0]        RATIO_RST = 32'd1073741824;
  localparam logic [COUNT_W-1:0] COUNT_RST = 28'd48000;

  // Configuration register set.
  typedef struct packed {
    logic               sweep_mode;
    logic [30:0]        start_step;
    logic [31:0]        step_delta;
    logic [31:0]        step_ratio;
    logic [COUNT_W-1:0] sample_count;
  } ssc_cfg_t;

  // Per-word side information that travels alongside the table read.
  typedef struct packed {
    logic neg;
    logic last;
  } ssc_tap_t;

  // One quarter-wave table entry: a truncating Horner series for sin(x)
  // through x^11 in Q2.30, scaled to Q1.15 with rounding and clamped.
  function automatic logic [QVAL_W-1:0] qtab_entry(input logic [63:0] i, input int tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (HALF_PI_Q30 * i) >> tb;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    r  = (s * Q15_MAX + (64'd1 << 29)) >> 30;
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end
    return QVAL_W'(r);
  endfunction

endpackage

// ----- sv/ssc_ifs.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator channel interfaces
// Valid/ready channels for the input, result and configuration words.
// ----------------------------------------------------------------------------

// Input channel: one word requests one sample.
interface ssc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Result channel: one sample with its end-of-sweep flag.
interface ssc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Configuration write channel.
interface ssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/ssc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator configuration registers
// Holds the sweep settings written through the configuration channel.
// ----------------------------------------------------------------------------
module ssc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ssc_cfg_if.sink           cfg_chan,
  output ssc_pkg::ssc_cfg_t cfg
);
  import ssc_pkg::*;

  ssc_cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_chan.ready = 1'b1;
  assign cfg            = cfg_r;

  // Register file; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_mode   <= MODE_LINEAR;
      cfg_r.start_step   <= '0;
      cfg_r.step_delta   <= '0;
      cfg_r.step_ratio   <= RATIO_RST;
      cfg_r.sample_count <= COUNT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_SWEEP_MODE:   cfg_r.sweep_mode   <= cfg_chan.data[0];
        REG_START_STEP:   cfg_r.start_step   <= cfg_chan.data[30:0];
        REG_STEP_DELTA:   cfg_r.step_delta   <= cfg_chan.data;
        REG_STEP_RATIO:   cfg_r.step_ratio   <= cfg_chan.data;
        REG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_chan.data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/ssc_sweep.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator sweep state
// Phase accumulator, phase step and sample index, advanced once per word.
// ----------------------------------------------------------------------------
module ssc_sweep #(
  parameter int TABLE_BITS = ssc_pkg::TABLE_BITS_DEF,
  parameter int PHASE_BITS = ssc_pkg::PHASE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ssc_pkg::ssc_cfg_t   cfg,
  input  logic                fire,
  input  logic                restart,
  output logic [TABLE_BITS:0] rom_addr,
  output ssc_pkg::ssc_tap_t   tap
);
  import ssc_pkg::*;

  // Step width, and widths for the saturating step arithmetic.
  localparam int SW = PHASE_BITS - 1;
  localparam int CW = (SW > 31) ? SW : 31;
  localparam int LW = (((SW + 1) > 32) ? (SW + 1) : 32) + 1;
  localparam int PW = SW + 32;
  localparam logic [TABLE_BITS:0] QTR = (TABLE_BITS + 1)'(1) << TABLE_BITS;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [SW-1:0]         step_r;
  logic [SW-1:0]         step_nxt;
  logic [COUNT_W-1:0]    index_r;
  logic [COUNT_W-1:0]    index_nxt;

  logic                   start;
  logic [CW-1:0]          start_wide;
  logic [SW-1:0]          step_start;
  logic [PHASE_BITS-1:0]  phase_cur;
  logic [SW-1:0]          step_cur;
  logic [COUNT_W-1:0]     index_cur;
  logic [COUNT_W-1:0]     count;
  logic                   last;
  logic signed [LW-1:0]   lin_sum;
  logic [SW-1:0]          lin_step;
  logic [PW-1:0]          prod;
  logic [SW+1:0]          scaled;
  logic [SW-1:0]          log_step;
  logic [TABLE_BITS+1:0]  top;
  logic [1:0]             quad;
  logic [TABLE_BITS-1:0]  idx;

  // Sweep start selection and the values for the current sample.
  always_comb begin
    start      = restart || (index_r == '0);
    start_wide = CW'(cfg.start_step);
    step_start = (start_wide > CW'({SW{1'b1}})) ? {SW{1'b1}} : SW'(start_wide);
    phase_cur  = start ? '0 : phase_r;
    step_cur   = start ? step_start : step_r;
    index_cur  = start ? '0 : index_r;
    count      = (cfg.sample_count == '0) ? COUNT_W'(1) : cfg.sample_count;
    last       = ({1'b0, index_cur} + (COUNT_W + 1)'(1)) >= {1'b0, count};
  end

  // Linear step: add the signed delta and clamp to the step range.
  always_comb begin
    lin_sum = signed'(LW'(step_cur)) + LW'(signed'(cfg.step_delta));
    if (lin_sum[LW-1]) begin
      lin_step = '0;
    end else if (|lin_sum[LW-2:SW]) begin
      lin_step = {SW{1'b1}};
    end else begin
      lin_step = lin_sum[SW-1:0];
    end
  end

  // Logarithmic step: Q2.30 multiply with rounding, then saturate.
  always_comb begin
    prod     = PW'(step_cur) * PW'(cfg.step_ratio) + PW'(64'd1 << 29);
    scaled   = prod[PW-1:30];
    log_step = (|scaled[SW+1:SW]) ? {SW{1'b1}} : scaled[SW-1:0];
  end

  // Quarter-wave table address and sign from the top phase bits.
  always_comb begin
    top      = phase_cur[PHASE_BITS-1 -: TABLE_BITS + 2];
    quad     = top[TABLE_BITS+1:TABLE_BITS];
    idx      = top[TABLE_BITS-1:0];
    rom_addr = quad[0] ? (QTR - {1'b0, idx}) : {1'b0, idx};
    tap.neg  = quad[1];
    tap.last = last;
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_cur + PHASE_BITS'(step_cur);
    step_nxt  = (cfg.sweep_mode == MODE_LOG) ? log_step : lin_step;
    index_nxt = last ? '0 : (index_cur + COUNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      index_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

// ----- sv/ssc_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator sine table
// Quarter-wave sine table in Q1.15 magnitude with a registered read.
// ----------------------------------------------------------------------------
module ssc_sine_rom #(
  parameter int TABLE_BITS = ssc_pkg::TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [TABLE_BITS:0]         rd_addr,
  output logic [ssc_pkg::QVAL_W-1:0]  rd_data
);
  import ssc_pkg::*;

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  typedef logic [QVAL_W-1:0] rom_arr_t [DEPTH];

  // Table contents, worked out at elaboration.
  function automatic rom_arr_t build_rom();
    rom_arr_t tab;
    for (int i = 0; i < DEPTH; i++) begin
      tab[i] = qtab_entry(64'(i), TABLE_BITS);
    end
    return tab;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [QVAL_W-1:0] rd_data_r;

  // Registered read; the data holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/swept_sine_chirp_generator.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator
// Linear or logarithmic frequency sweep built on a phase accumulator.
// ----------------------------------------------------------------------------
// Each input word asks for one sample and yields exactly one result word, a
// Q1.15 sine sample with a flag on the final sample of the sweep. A new word
// is taken in every cycle while the result side keeps up. Each taken word
// advances the phase, step and sample index and reads the quarter-wave table
// into the table stage register, then its sign is applied into the output
// register. The rate is one sample per cycle while the result side keeps up,
// set by the step update loop, closing through one add or one multiply. The
// user must write configuration only while the block is idle; it is unchecked.
module swept_sine_chirp_generator #(
  parameter int TABLE_BITS = ssc_pkg::TABLE_BITS_DEF,
  parameter int PHASE_BITS = ssc_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if.sink      in_chan,
  ssc_out_if.source   out_chan,
  ssc_cfg_if.sink     cfg_chan
);
  import ssc_pkg::*;

  ssc_cfg_t              cfg;
  logic                  in_fire;
  logic                  out_load;
  logic [TABLE_BITS:0]   rom_addr;
  logic [QVAL_W-1:0]     rom_data;
  ssc_tap_t              tap;

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  ssc_tap_t              s1_tap_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_sample_r;
  logic                  out_last_r;

  ssc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  ssc_sweep #(
    .TABLE_BITS (TABLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .fire     (in_fire),
    .restart  (in_chan.restart),
    .rom_addr (rom_addr),
    .tap      (tap)
  );

  ssc_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // Pipeline handshake: the table stage moves on whenever the output
  // register is empty or its word is being taken.
  always_comb begin
    out_load       = s1_valid_r && (!out_valid_r || out_chan.ready);
    in_chan.ready  = !s1_valid_r || out_load;
    in_fire        = in_chan.valid && in_chan.ready;
    s1_valid_nxt   = in_fire || (s1_valid_r && !out_load);
    out_valid_nxt  = out_load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Side information kept alongside the table read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tap_r <= tap;
    end
  end

  // Output register: apply the quadrant sign to the table magnitude.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= s1_tap_r.neg ? (SAMPLE_W'(0) - SAMPLE_W'(rom_data))
                                   : SAMPLE_W'(rom_data);
      out_last_r   <= s1_tap_r.last;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.sample = signed'(out_sample_r);
  assign out_chan.last   = out_last_r;

endmodule

// ----- dv/ssc_checker.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator checker
// Watches the request, result and register channels of the chirp generator,
// keeps its own copy of the sweep state and registers, predicts one sample
// word for every request word and compares each result word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ssc_checker (
  input  logic        clk,
  input  logic        rst_n,
  ssc_in_if           in_mon,
  ssc_out_if          out_mon,
  ssc_cfg_if          cfg_mon,
  output int unsigned pending,
  output int unsigned fail_count
);
  import ssc_pkg::*;

  localparam int TBITS     = TABLE_BITS_DEF;
  localparam int PBITS     = PHASE_BITS_DEF;
  localparam int QTAB_LAST = 1 << TBITS;
  localparam logic [63:0] STEP_MAX = (64'd1 << (PBITS - 1)) - 64'd1;

  // One predicted result word.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } chirp_word_t;

  // Quarter-wave sine magnitudes, Q1.15.
  logic [QVAL_W-1:0] quarter_sine [0:QTAB_LAST];

  // Shadow copy of the registers.
  logic               mode_r;
  logic [30:0]        start_r;
  logic [31:0]        delta_r;
  logic [31:0]        ratio_r;
  logic [COUNT_W-1:0] count_r;

  // Shadow copy of the sweep state.
  logic [PBITS-1:0]   acc_q;
  logic [PBITS-2:0]   step_q;
  logic [COUNT_W-1:0] idx_q;

  // Result words that are owed, oldest first.
  chirp_word_t due_words [$];

  // Build the quarter table from a truncating Horner series of sin(x) in Q2.30.
  initial begin : build_quarter_table
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] poly;
    logic [63:0] scaled;
    for (int i = 0; i <= QTAB_LAST; i++) begin
      ang    = (HALF_PI_Q30 * 64'(i)) >> TBITS;
      ang_sq = (ang * ang) >> 30;
      poly   = ONE_Q30 - ang_sq / 64'd110;
      poly   = ONE_Q30 - ((ang_sq * poly) >> 30) / 64'd72;
      poly   = ONE_Q30 - ((ang_sq * poly) >> 30) / 64'd42;
      poly   = ONE_Q30 - ((ang_sq * poly) >> 30) / 64'd20;
      poly   = ONE_Q30 - ((ang_sq * poly) >> 30) / 64'd6;
      scaled = (((ang * poly) >> 30) * Q15_MAX + (64'd1 << 29)) >> 30;
      quarter_sine[i] = (scaled > Q15_MAX) ? QVAL_W'(Q15_MAX) : QVAL_W'(scaled);
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] chirp check: %s", $time, what);
    fail_count++;
  endtask

  // Advance the shadow sweep by one request word and return the sample it owes.
  function automatic chirp_word_t next_chirp(input logic restart);
    logic [COUNT_W-1:0] span;
    logic [TBITS+1:0]   top;
    logic [TBITS-1:0]   ent;
    logic [QVAL_W-1:0]  mag;
    logic [63:0]        prod;
    longint             sum;
    chirp_word_t        w;
    span = (count_r == '0) ? COUNT_W'(1) : count_r;

    // A restart, or an index that has wrapped to zero, opens a new sweep.
    if (restart || idx_q == '0) begin
      idx_q  = '0;
      acc_q  = '0;
      step_q = start_r;
    end

    // Quadrant from the two top phase bits, table entry from the next ones.
    top = acc_q[PBITS-1 -: TBITS+2];
    ent = top[TBITS-1:0];
    mag = top[TBITS] ? quarter_sine[QTAB_LAST - int'(ent)] : quarter_sine[ent];
    w.sample = top[TBITS+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    w.last   = (32'(idx_q) + 32'd1) >= 32'(span);

    acc_q = acc_q + PBITS'(step_q);

    // Step update: rounded Q2.30 multiply in log mode, clamped add in linear mode.
    if (mode_r == MODE_LOG) begin
      prod   = (64'(step_q) * 64'(ratio_r) + (64'd1 << 29)) >> 30;
      step_q = (prod > STEP_MAX) ? STEP_MAX[PBITS-2:0] : prod[PBITS-2:0];
    end else begin
      sum = longint'(step_q) + longint'($signed(delta_r));
      if (sum < 0) begin
        step_q = '0;
      end else if (sum > longint'(STEP_MAX)) begin
        step_q = STEP_MAX[PBITS-2:0];
      end else begin
        step_q = sum[PBITS-2:0];
      end
    end

    idx_q = w.last ? '0 : idx_q + COUNT_W'(1);
    return w;
  endfunction

  // Track registers, predict on each request word and check each result word.
  always @(posedge clk) begin : watch
    chirp_word_t want;
    if (!rst_n) begin
      mode_r     = MODE_LINEAR;
      start_r    = '0;
      delta_r    = '0;
      ratio_r    = RATIO_RST;
      count_r    = COUNT_RST;
      acc_q      = '0;
      step_q     = '0;
      idx_q      = '0;
      fail_count = 0;
      due_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (ssc_reg_e'(cfg_mon.index))
          REG_SWEEP_MODE:   mode_r  = cfg_mon.data[0];
          REG_START_STEP:   start_r = cfg_mon.data[30:0];
          REG_STEP_DELTA:   delta_r = cfg_mon.data;
          REG_STEP_RATIO:   ratio_r = cfg_mon.data;
          REG_SAMPLE_COUNT: count_r = cfg_mon.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        due_words.push_back(next_chirp(in_mon.restart));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d/%0b with no request outstanding",
                                    out_mon.sample, out_mon.last));
        end else begin
          want = due_words.pop_front();
          if (out_mon.sample !== want.sample) begin
            report_mismatch($sformatf("sample %0d, expected %0d", out_mon.sample, want.sample));
          end
          if (out_mon.last !== want.last) begin
            report_mismatch($sformatf("last flag %b, expected %b", out_mon.last, want.last));
          end
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Swept sine chirp generator testbench
// Drives request words and register writes into the chirp generator with
// random pacing on both channels, first through a set of directed sweeps and
// then through randomly configured linear and log sweeps. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ssc_pkg::*;

  // Longest correct stretch without a handshake is about two long stalls
  // plus the pipeline, well under the stall limit.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int          RANDOM_PHASES = 12;

  logic        clk;
  logic        rst_n;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;

  ssc_in_if  in_if ();
  ssc_out_if out_if ();
  ssc_cfg_if cfg_if ();

  swept_sine_chirp_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  ssc_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle length drawn from three ranges: usually the shortest, sometimes the middle one, rarely the longest.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return $urandom_range(1, 2);
    end else if (roll < 93) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  // Present one request word and hold it until it is taken.
  task automatic send_request(input logic restart);
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // A run of request words; calm stretches of 40 words have no source gaps.
  task automatic run_items(input int unsigned n, input int unsigned restart_pct);
    bit calm;
    calm = 1'b0;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      send_request($urandom_range(0, 99) < restart_pct);
      if (!calm && $urandom_range(0, 99) < 30) begin
        in_if.valid <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // Wait until every owed result word is back and the pipeline has drained.
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ssc_reg_e idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Reprogram the whole register set while the block is idle.
  task automatic program_sweep(input logic [31:0] mode, input logic [31:0] start,
                               input logic [31:0] delta, input logic [31:0] ratio,
                               input logic [31:0] count);
    settle();
    write_reg(REG_SWEEP_MODE, mode);
    write_reg(REG_START_STEP, start);
    write_reg(REG_STEP_DELTA, delta);
    write_reg(REG_STEP_RATIO, ratio);
    write_reg(REG_SAMPLE_COUNT, count);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: ready bursts broken by stalls, now and then a long clear run.
  initial begin : result_pacing
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_if.ready <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] mode_w;
    logic [31:0] start_w;
    logic [31:0] delta_w;
    logic [31:0] ratio_w;
    logic [31:0] count_w;
    logic [31:0] mag;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_SWEEP_MODE;
    cfg_if.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: zero step, so the sweep sits at phase zero.
    run_items(2, 0);

    // Quarter-turn steps land on each quadrant boundary, last on the sixth word.
    program_sweep(32'(MODE_LINEAR), 32'h4000_0000, 32'h0, RATIO_RST, 32'd6);
    run_items(6, 0);

    // Largest step and delta clamp at the top; the third word restarts.
    program_sweep(32'(MODE_LINEAR), 32'h7FFF_FFFF, 32'h7FFF_FFFF, RATIO_RST, 32'd3);
    run_items(2, 0);
    run_items(1, 100);

    // Most negative delta clamps the step at zero.
    program_sweep(32'(MODE_LINEAR), 32'h7FFF_FFFF, 32'h8000_0000, RATIO_RST, 32'd4);
    run_items(3, 0);

    // Log mode with the largest ratio saturates; a count of zero acts as one.
    program_sweep(32'(MODE_LOG), 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd0);
    run_items(3, 0);

    // Zero ratio collapses the step after the first word.
    program_sweep(32'(MODE_LOG), 32'd1000, 32'h0, 32'h0, 32'd2);
    run_items(2, 0);

    // Largest count, then shrink it under the running index: next word is last.
    program_sweep(32'(MODE_LINEAR), 32'd12345, 32'd1, RATIO_RST, 32'h0FFF_FFFF);
    run_items(4, 0);
    settle();
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    cfg_if.valid <= 1'b0;
    run_items(2, 0);

    // Randomly configured sweeps, mostly short so that wraps come often.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode_w = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0:       start_w = 32'h0;
        1:       start_w = 32'h7FFF_FFFF;
        2:       start_w = $urandom();
        default: start_w = $urandom_range(0, 32'h0400_0000);
      endcase
      mag = $urandom_range(0, 1 << 20);
      case ($urandom_range(0, 4))
        0:       delta_w = 32'h0;
        1:       delta_w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        2:       delta_w = $urandom();
        default: delta_w = $urandom_range(0, 1) ? mag : (~mag + 32'd1);
      endcase
      case ($urandom_range(0, 3))
        0:       ratio_w = $urandom();
        1:       ratio_w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: ratio_w = RATIO_RST + $urandom_range(0, 1 << 24) - 32'h0080_0000;
      endcase
      case ($urandom_range(0, 5))
        0:       count_w = $urandom_range(0, 1);
        1:       count_w = 32'h0FFF_FFFF;
        2:       count_w = $urandom();
        default: count_w = $urandom_range(2, 60);
      endcase
      program_sweep(mode_w, start_w, delta_w, ratio_w, count_w);
      run_items($urandom_range(90, 135), $urandom_range(0, 8));
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
